// ----- hw/rtl/assert_macros.svh -----
// assertion helpers used by sbjh_back
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_IMPL(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define ASSERT_NEVER(label, clk, rstn, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`endif

// ----- hw/rtl/sbjh_pkg.sv -----
// ----------------------------------------------------------------------------
// sbjh_pkg
// shared types and constants of the soft binned joint histogram
// ----------------------------------------------------------------------------
`default_nettype none
package sbjh_pkg;
    localparam int MAX_BINS_DEF  = 16;
    localparam int BIN_WIDTH_DEF = 32;
    localparam logic [1:0] KIND_ADD    = 2'd0;
    localparam logic [1:0] KIND_READ   = 2'd1;
    localparam logic [1:0] KIND_CLEAR  = 2'd2;
    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam logic [1:0] CFG_BINS   = 2'd0;
    localparam logic [1:0] CFG_INV    = 2'd1;
    localparam logic [1:0] CFG_WEIGHT = 2'd2;
    localparam logic [16:0] ONE_Q16   = 17'h10000;
endpackage
`default_nettype wire

// ----- hw/rtl/sbjh_front.sv -----
// ----------------------------------------------------------------------------
// sbjh_front
// one axis split: bin coordinate, nearest bin, neighbor and share
// ----------------------------------------------------------------------------
`default_nettype none
module sbjh_front #(
    parameter int MAX_BINS = sbjh_pkg::MAX_BINS_DEF,
    localparam int IW = $clog2(MAX_BINS)
) (
    input  wire logic [15:0]   value,
    input  wire logic [23:0]   inv_step,
    input  wire logic [6:0]    n_bins,
    output logic      [IW-1:0] bin,
    output logic      [IW-1:0] nb,
    output logic               has_nb,
    output logic      [16:0]   share
);
    logic [39:0] prod;
    logic [23:0] c;
    logic [16:0] b;
    logic [24:0] centre;
    logic [24:0] tail;
    logic [15:0] tt;
    logic [16:0] tsq;
    always_comb begin
        prod   = {24'd0, value} * {16'd0, inv_step};
        c      = prod[39:16];
        b      = 17'((25'(c) + 25'd128) >> 8);
        centre = {b, 8'd0};
        tail   = (centre > 25'(c)) ? centre - 25'(c) : 25'(c) - centre;
        tt     = 16'(tail[7:0]) * 16'(tail[7:0]);
        tsq    = {tt, 1'b0};
        has_nb = 1'b0;
        share  = sbjh_pkg::ONE_Q16;
        if (b >= 17'(n_bins)) begin
            bin = IW'(n_bins - 7'd1);
            nb  = bin;
        end else begin
            bin = IW'(b);
            nb  = bin;
            if (centre < 25'(c) && b < 17'(n_bins - 7'd1)) begin
                nb = bin + IW'(1);
                has_nb = 1'b1;
            end else if (centre > 25'(c) && b != 17'd0) begin
                nb = bin - IW'(1);
                has_nb = 1'b1;
            end
            if (has_nb) share = sbjh_pkg::ONE_Q16 - tsq;
        end
    end
endmodule
`default_nettype wire

// ----- hw/rtl/sbjh_back.sv -----
// ----------------------------------------------------------------------------
// sbjh_back
// bin store: weighted increments, saturating add, read and clear
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module sbjh_back #(
    parameter int MAX_BINS = sbjh_pkg::MAX_BINS_DEF,
    localparam int IW = $clog2(MAX_BINS),
    localparam int AW = 2 * IW,
    localparam int DEPTH = 2 ** AW
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          q_valid,
    output logic               q_ready,
    input  wire logic [1:0]    q_kind,
    input  wire logic [IW-1:0] q_rbin,
    input  wire logic [IW-1:0] q_rnb,
    input  wire logic          q_rhas,
    input  wire logic [16:0]   q_rshare,
    input  wire logic [IW-1:0] q_cbin,
    input  wire logic [IW-1:0] q_cnb,
    input  wire logic          q_chas,
    input  wire logic [16:0]   q_cshare,
    input  wire logic          q_rd_ok,
    input  wire logic [AW-1:0] q_raddr,
    input  wire logic [23:0]   weight,
    output logic               r_valid,
    input  wire logic          r_ready,
    output logic [31:0]        r_data
);
    localparam logic [2:0] ST_IDLE = 3'd0, ST_MUL1 = 3'd1, ST_MUL2 = 3'd2;
    localparam logic [2:0] ST_RD = 3'd3, ST_WR = 3'd4, ST_RRD = 3'd5;
    localparam logic [2:0] ST_RRES = 3'd6, ST_CLR = 3'd7;

    logic [31:0] mem [DEPTH];
    logic [DEPTH-1:0] wr_reg;
    logic [2:0]  state_reg;
    logic [1:0]  step_reg;
    logic [AW-1:0] addr_reg;
    logic [40:0] p1_reg;
    logic [31:0] inc_reg;
    logic [31:0] rdata_reg;
    logic        rok_reg;
    logic [IW-1:0] rbin_reg, rnb_reg, cbin_reg, cnb_reg;
    logic        rhas_reg, chas_reg;
    logic [16:0] rsh_reg, csh_reg;
    logic [16:0] rs, cs;
    logic [IW-1:0] row, col;
    logic        skip;
    logic [32:0] sum;

    always_comb begin
        row = step_reg[1] ? rnb_reg : rbin_reg;
        col = step_reg[0] ? cnb_reg : cbin_reg;
        rs  = step_reg[1] ? sbjh_pkg::ONE_Q16 - rsh_reg : rsh_reg;
        cs  = step_reg[0] ? sbjh_pkg::ONE_Q16 - csh_reg : csh_reg;
        skip = (step_reg[1] && !rhas_reg) || (step_reg[0] && !chas_reg);
        sum = {1'b0, wr_reg[addr_reg] ? rdata_reg : 32'd0} + {1'b0, inc_reg};
    end

    assign q_ready = (state_reg == ST_IDLE) && !r_valid;

    always_ff @(posedge aclk) begin
        if (state_reg == ST_WR) mem[addr_reg] <= sum[32] ? 32'hFFFFFFFF : sum[31:0];
        rdata_reg <= mem[(state_reg == ST_RRD) ? q_raddr : addr_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            step_reg  <= 2'd0;
            wr_reg    <= '0;
            r_valid   <= 1'b0;
        end else begin
            if (r_valid && r_ready) r_valid <= 1'b0;
            unique case (state_reg)
                ST_IDLE: if (q_valid && !r_valid) begin
                    step_reg <= 2'd0;
                    rbin_reg <= q_rbin;
                    rnb_reg  <= q_rnb;
                    rhas_reg <= q_rhas;
                    rsh_reg  <= q_rshare;
                    cbin_reg <= q_cbin;
                    cnb_reg  <= q_cnb;
                    chas_reg <= q_chas;
                    csh_reg  <= q_cshare;
                    priority if (q_kind == sbjh_pkg::KIND_ADD) state_reg <= ST_MUL1;
                    else if (q_kind == sbjh_pkg::KIND_READ) state_reg <= ST_RRD;
                    else if (q_kind == sbjh_pkg::KIND_CLEAR) state_reg <= ST_CLR;
                    else state_reg <= ST_IDLE;
                end
                ST_MUL1: begin
                    if (skip) begin
                        step_reg <= step_reg + 2'd1;
                        if (step_reg == 2'd3) state_reg <= ST_IDLE;
                    end else begin
                        p1_reg <= 41'({24'd0, weight} * {41'd0, rs});
                        addr_reg <= {row, col};
                        state_reg <= ST_MUL2;
                    end
                end
                ST_MUL2: begin
                    inc_reg <= 32'((58'(p1_reg) * 58'(cs) + 58'h80000000) >> 32);
                    state_reg <= ST_RD;
                end
                ST_RD: state_reg <= ST_WR;
                ST_WR: begin
                    wr_reg[addr_reg] <= 1'b1;
                    step_reg <= step_reg + 2'd1;
                    state_reg <= (step_reg == 2'd3) ? ST_IDLE : ST_MUL1;
                end
                ST_RRD: begin
                    rok_reg <= q_rd_ok && wr_reg[q_raddr];
                    state_reg <= ST_RRES;
                end
                ST_RRES: begin
                    r_data <= rok_reg ? rdata_reg : 32'd0;
                    r_valid <= 1'b1;
                    state_reg <= ST_IDLE;
                end
                ST_CLR: begin
                    wr_reg <= '0;
                    state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    `ASSERT_NEVER(a_ready_busy, aclk, aresetn, q_ready && state_reg != ST_IDLE, "ready while busy")
    `ASSERT_IMPL(a_wr_sets, aclk, aresetn, state_reg == ST_WR |=> wr_reg[$past(addr_reg)], "flag")
    `ASSERT_IMPL(a_res_hold, aclk, aresetn, r_valid && !r_ready |=> r_valid && $stable(r_data), "hold")
endmodule
`default_nettype wire

// ----- hw/rtl/soft_binned_joint_histogram.sv -----
// ----------------------------------------------------------------------------
// soft_binned_joint_histogram
// soft binned joint intensity histogram for mutual information
// ----------------------------------------------------------------------------
// The front splits both intensities into bins and shares in the accept
// cycle and parks the beat in a one-entry queue. The back updates up to four
// bins through one read-modify-write port of the store, each in the states
// MUL1, MUL2, RD and WR; a read result sits in an output register while the
// next beat may queue.
`default_nettype none
module soft_binned_joint_histogram #(
    parameter int MAX_BINS = sbjh_pkg::MAX_BINS_DEF,
    localparam int IW = $clog2(MAX_BINS)
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [23:0] cfg_data,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_kind,
    input  wire logic [15:0] s_first_value,
    input  wire logic [15:0] s_second_value,
    input  wire logic [3:0]  s_read_row,
    input  wire logic [3:0]  s_read_col,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [31:0]      m_bin_value
);
    logic [4:0]  bins_reg;
    logic [23:0] inv_reg, wgt_reg;
    logic [6:0]  n_bins;
    logic [IW-1:0] cb, cn, rb, rn;
    logic ch, rh;
    logic [16:0] csh, rsh;
    logic q_valid_reg, q_ready;
    logic [1:0] k_reg;
    logic [IW-1:0] rb_reg, rn_reg, cb_reg, cn_reg, rdr_reg, rdc_reg;
    logic rh_reg, ch_reg, rok_reg;
    logic [16:0] rs_reg, cs_reg;

    assign cfg_ready = 1'b1;
    assign s_ready = !q_valid_reg;
    always_comb begin
        n_bins = 7'(bins_reg);
        if (bins_reg < 5'd2) n_bins = 7'd2;
        if (7'(bins_reg) > 7'(MAX_BINS)) n_bins = 7'(MAX_BINS);
    end

    sbjh_front #(.MAX_BINS(MAX_BINS)) u_col (.value(s_first_value), .inv_step(inv_reg),
        .n_bins(n_bins), .bin(cb), .nb(cn), .has_nb(ch), .share(csh));
    sbjh_front #(.MAX_BINS(MAX_BINS)) u_row (.value(s_second_value), .inv_step(inv_reg),
        .n_bins(n_bins), .bin(rb), .nb(rn), .has_nb(rh), .share(rsh));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bins_reg <= 5'd16;
            inv_reg  <= 24'd65536;
            wgt_reg  <= 24'd65536;
            q_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                unique case (cfg_index)
                    sbjh_pkg::CFG_BINS:   bins_reg <= cfg_data[4:0];
                    sbjh_pkg::CFG_INV:    inv_reg  <= cfg_data;
                    sbjh_pkg::CFG_WEIGHT: wgt_reg  <= cfg_data;
                    default: ;
                endcase
            end
            if (s_valid && s_ready) q_valid_reg <= 1'b1;
            else if (q_ready) q_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            k_reg <= s_kind;
            rb_reg <= rb; rn_reg <= rn; rh_reg <= rh; rs_reg <= rsh;
            cb_reg <= cb; cn_reg <= cn; ch_reg <= ch; cs_reg <= csh;
            rok_reg <= 32'(s_read_row) < MAX_BINS && 32'(s_read_col) < MAX_BINS;
            rdr_reg <= IW'(s_read_row);
            rdc_reg <= IW'(s_read_col);
        end
    end

    sbjh_back #(.MAX_BINS(MAX_BINS)) u_back (
        .aclk(aclk), .aresetn(aresetn), .q_valid(q_valid_reg), .q_ready(q_ready),
        .q_kind(k_reg), .q_rbin(rb_reg), .q_rnb(rn_reg), .q_rhas(rh_reg),
        .q_rshare(rs_reg), .q_cbin(cb_reg), .q_cnb(cn_reg), .q_chas(ch_reg),
        .q_cshare(cs_reg), .q_rd_ok(rok_reg), .q_raddr({rdr_reg, rdc_reg}),
        .weight(wgt_reg), .r_valid(m_valid), .r_ready(m_ready), .r_data(m_bin_value));
endmodule
`default_nettype wire

// ----- dv/soft_binned_joint_histogram_checker.sv -----
// ----------------------------------------------------------------------------
// soft_binned_joint_histogram_checker
// watches the config, input and result channels of the joint histogram,
// keeps its own copy of the registers and the bin store, predicts every
// read result and compares it with the result beats in order
// ----------------------------------------------------------------------------
`default_nettype none
module soft_binned_joint_histogram_checker (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_valid,
    input  wire logic        cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [23:0] cfg_data,
    input  wire logic        s_valid,
    input  wire logic        s_ready,
    input  wire logic [1:0]  s_kind,
    input  wire logic [15:0] s_first_value,
    input  wire logic [15:0] s_second_value,
    input  wire logic [3:0]  s_read_row,
    input  wire logic [3:0]  s_read_col,
    input  wire logic        m_valid,
    input  wire logic        m_ready,
    input  wire logic [31:0] m_bin_value,
    output int               fail_count,
    output int               pending_reads,
    output int               reads_checked
);
    localparam int NB = sbjh_pkg::MAX_BINS_DEF;

    logic [4:0]  bins_reg;
    logic [23:0] inv_step_reg;
    logic [23:0] weight_reg;
    logic [31:0] hist [NB*NB];
    logic [31:0] expected_bins [$];

    typedef struct {
        int unsigned bin;
        int unsigned nbr;
        bit          has_nbr;
        logic [16:0] share;
    } axis_split_t;

    function automatic axis_split_t split_value(logic [15:0] v, int unsigned n);
        axis_split_t a;
        logic [63:0] c;
        logic [63:0] b;
        logic [63:0] ctr;
        logic [63:0] tl;
        c = (64'(v) * 64'(inv_step_reg)) >> 16;
        b = (c + 64'd128) >> 8;
        ctr = b << 8;
        tl = (ctr > c) ? ctr - c : c - ctr;
        a.has_nbr = 0;
        a.share = sbjh_pkg::ONE_Q16;
        if (b >= 64'(n)) begin
            a.bin = n - 1;
            a.nbr = a.bin;
            return a;
        end
        a.bin = int'(b);
        a.nbr = a.bin;
        if (c > ctr && b < 64'(n - 1)) begin
            a.nbr = a.bin + 1;
            a.has_nbr = 1;
        end else if (c < ctr && b > 0) begin
            a.nbr = a.bin - 1;
            a.has_nbr = 1;
        end
        if (a.has_nbr) a.share = 17'(65536 - 2 * tl * tl);
        return a;
    endfunction

    task automatic accumulate_pair(logic [15:0] fv, logic [15:0] sv);
        int unsigned n;
        axis_split_t ca;
        axis_split_t ra;
        int unsigned rw;
        int unsigned cl;
        logic [63:0] rs;
        logic [63:0] cs;
        logic [63:0] p;
        logic [63:0] sum;
        n = bins_reg < 2 ? 2 : (bins_reg > NB ? NB : bins_reg);
        ca = split_value(fv, n);
        ra = split_value(sv, n);
        for (int i = 0; i < 2; i++) begin
            if (i == 1 && !ra.has_nbr) break;
            rw = i ? ra.nbr : ra.bin;
            rs = i ? 64'(65536 - ra.share) : 64'(ra.share);
            for (int j = 0; j < 2; j++) begin
                if (j == 1 && !ca.has_nbr) break;
                cl = j ? ca.nbr : ca.bin;
                cs = j ? 64'(65536 - ca.share) : 64'(ca.share);
                p = 64'(weight_reg) * rs * cs;
                sum = 64'(hist[rw*NB+cl]) + ((p + 64'h8000_0000) >> 32);
                if (sum > 64'hFFFF_FFFF) sum = 64'hFFFF_FFFF;
                hist[rw*NB+cl] = sum[31:0];
            end
        end
    endtask

    task automatic report_mismatch(string what);
        $display("mismatch: %s", what);
        fail_count++;
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            bins_reg <= 5'd16;
            inv_step_reg <= 24'd65536;
            weight_reg <= 24'd65536;
            for (int k = 0; k < NB*NB; k++) hist[k] = '0;
            expected_bins.delete();
            fail_count = 0;
            reads_checked <= 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    sbjh_pkg::CFG_BINS: bins_reg <= cfg_data[4:0];
                    sbjh_pkg::CFG_INV: inv_step_reg <= cfg_data;
                    sbjh_pkg::CFG_WEIGHT: weight_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                case (s_kind)
                    sbjh_pkg::KIND_ADD: accumulate_pair(s_first_value, s_second_value);
                    sbjh_pkg::KIND_READ:
                        expected_bins = {expected_bins, hist[s_read_row*NB+s_read_col]};
                    sbjh_pkg::KIND_CLEAR: for (int k = 0; k < NB*NB; k++) hist[k] = '0;
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                reads_checked <= reads_checked + 1;
                if (expected_bins.size() == 0) begin
                    report_mismatch($sformatf("unexpected result %h", m_bin_value));
                end else begin
                    if (m_bin_value !== expected_bins[0])
                        report_mismatch($sformatf("bin_value %h, expected %h",
                            m_bin_value, expected_bins[0]));
                    void'(expected_bins.pop_front());
                end
            end
        end
        pending_reads = expected_bins.size();
    end
endmodule
`default_nettype wire

// ----- dv/soft_binned_joint_histogram_test.sv -----
// ----------------------------------------------------------------------------
// soft_binned_joint_histogram_test
// drives add, read, clear and unused beats under several register settings with
// random gaps and result stalls; the checker predicts and compares reads
// ----------------------------------------------------------------------------
`default_nettype none
module soft_binned_joint_histogram_test;
    logic        aclk = 0;
    logic        aresetn = 0;
    logic        cfg_valid = 0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [23:0] cfg_data = '0;
    logic        s_valid = 0;
    logic        s_ready;
    logic [1:0]  s_kind = '0;
    logic [15:0] s_first_value = '0;
    logic [15:0] s_second_value = '0;
    logic [3:0]  s_read_row = '0;
    logic [3:0]  s_read_col = '0;
    logic        m_valid;
    logic        m_ready = 0;
    logic [31:0] m_bin_value;
    int          fail_count;
    int          pending_reads;
    int          reads_checked;
    int          cycle_count = 0;
    int          beats_sent = 0;
    int          stall_mode = 0;
    bit          end_of_run = 0;

    always begin
        #1 aclk = 1;
        #1 aclk = 0;
    end

    soft_binned_joint_histogram i_dut (.*);

    soft_binned_joint_histogram_checker i_checker (.*);

    function automatic int gap_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 400000 && !end_of_run) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Test completed with failures");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || stall_mode == 0) m_ready <= 1;
        else if (stall_mode == 1) m_ready <= ($urandom_range(0, 3) != 0);
        else m_ready <= ($urandom_range(0, 15) == 0);
    end

    // valid stays high after the beat is taken until the next gap or drain
    task automatic send_beat(logic [1:0] k, logic [15:0] fv, logic [15:0] sv,
                             logic [3:0] rr, logic [3:0] rc);
        int g;
        g = gap_length();
        if (g > 0) begin
            s_valid <= 0;
            repeat (g) @(posedge aclk);
        end
        s_valid <= 1;
        s_kind <= k;
        s_first_value <= fv;
        s_second_value <= sv;
        s_read_row <= rr;
        s_read_col <= rc;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        beats_sent++;
    endtask

    task automatic drain();
        s_valid <= 0;
        while (pending_reads != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [23:0] val);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 0;
        @(posedge aclk);
    endtask

    task automatic read_bins(int count);
        for (int i = 0; i < count; i++)
            send_beat(sbjh_pkg::KIND_READ, '0, '0, 4'($urandom), 4'($urandom));
    endtask

    task automatic random_phase(int count);
        int r;
        logic [15:0] fv;
        logic [15:0] sv;
        for (int i = 0; i < count; i++) begin
            if (i % 60 == 0) stall_mode = $urandom_range(0, 2);
            r = $urandom_range(0, 99);
            fv = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 4095));
            sv = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 4095));
            if (r < 60) send_beat(sbjh_pkg::KIND_ADD, fv, sv, 4'($urandom), 4'($urandom));
            else if (r < 95)
                send_beat(sbjh_pkg::KIND_READ, fv, sv, 4'($urandom), 4'($urandom));
            else if (r < 98)
                send_beat(sbjh_pkg::KIND_CLEAR, fv, sv, 4'($urandom), 4'($urandom));
            else send_beat(sbjh_pkg::KIND_UNUSED, fv, sv, 4'($urandom), 4'($urandom));
        end
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // directed: reset settings, edges, neighbors on both sides, top clamp
        send_beat(sbjh_pkg::KIND_ADD, 16'h0000, 16'h0000, '0, '0);
        send_beat(sbjh_pkg::KIND_ADD, 16'hFFFF, 16'hFFFF, '0, '0);
        send_beat(sbjh_pkg::KIND_ADD, 16'h0180, 16'h0240, '0, '0);
        send_beat(sbjh_pkg::KIND_ADD, 16'h0260, 16'h01A0, '0, '0);
        send_beat(sbjh_pkg::KIND_ADD, 16'h0F7F, 16'h0040, '0, '0);
        send_beat(sbjh_pkg::KIND_ADD, 16'h0EC0, 16'h0080, '0, '0);
        send_beat(sbjh_pkg::KIND_READ, '0, '0, 4'd0, 4'd0);
        send_beat(sbjh_pkg::KIND_READ, '0, '0, 4'd15, 4'd15);
        send_beat(sbjh_pkg::KIND_READ, '0, '0, 4'd2, 4'd1);
        send_beat(sbjh_pkg::KIND_READ, '0, '0, 4'd1, 4'd2);
        send_beat(sbjh_pkg::KIND_UNUSED, 16'hFFFF, 16'hFFFF, 4'hF, 4'hF);
        send_beat(sbjh_pkg::KIND_CLEAR, '0, '0, '0, '0);
        send_beat(sbjh_pkg::KIND_READ, '0, '0, 4'd0, 4'd0);
        drain();

        // saturation: max weight, many pairs into one bin
        write_reg(sbjh_pkg::CFG_WEIGHT, 24'hFFFFFF);
        write_reg(sbjh_pkg::CFG_BINS, 24'd0);
        for (int i = 0; i < 300; i++)
            send_beat(sbjh_pkg::KIND_ADD, 16'h0000, 16'h0000, '0, '0);
        send_beat(sbjh_pkg::KIND_READ, '0, '0, 4'd0, 4'd0);
        send_beat(sbjh_pkg::KIND_ADD, 16'h0500, 16'h0080, '0, '0);
        send_beat(sbjh_pkg::KIND_READ, '0, '0, 4'd0, 4'd1);
        send_beat(sbjh_pkg::KIND_READ, '0, '0, 4'd1, 4'd1);
        drain();

        write_reg(sbjh_pkg::CFG_BINS, 24'd31);
        write_reg(sbjh_pkg::CFG_INV, 24'hFFFFFF);
        write_reg(sbjh_pkg::CFG_WEIGHT, 24'd0);
        send_beat(sbjh_pkg::KIND_ADD, 16'h0001, 16'h0001, '0, '0);
        read_bins(16);
        drain();

        for (int ph = 0; ph < 4; ph++) begin
            send_beat(sbjh_pkg::KIND_CLEAR, '0, '0, '0, '0);
            drain();
            write_reg(sbjh_pkg::CFG_BINS, 24'($urandom_range(2, 16)));
            write_reg(sbjh_pkg::CFG_INV,
                ph == 0 ? 24'd0 : 24'($urandom_range(4096, 600000)));
            write_reg(sbjh_pkg::CFG_WEIGHT, 24'($urandom));
            random_phase(95);
            stall_mode = 0;
            read_bins(32);
            drain();
        end

        end_of_run = 1;
        if (fail_count == 0) begin
            $display("covered %0d beats, %0d read results checked, several settings",
                beats_sent, reads_checked);
            $display("Test completed successfully");
        end else begin
            $display("covered %0d beats, %0d mismatches", beats_sent, fail_count);
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule
`default_nettype wire
